// ----- rtl/core/hsvg_pkg.sv -----
// Package for the HSV to RGB converter: ramp codes, brightness table, helpers.
`timescale 1ns / 1ps
`default_nettype none

package hsvg_pkg;

  // Largest legal hue: ramp 5, position 255
  localparam logic [10:0] HUE_MAX = 11'd1535;

  // Ramp numbers taken from the upper hue bits
  typedef enum logic [2:0] {
    RAMP_RED_GREEN_UP   = 3'd0,
    RAMP_RED_DOWN       = 3'd1,
    RAMP_GREEN_BLUE_UP  = 3'd2,
    RAMP_GREEN_DOWN     = 3'd3,
    RAMP_BLUE_RED_UP    = 3'd4,
    RAMP_BLUE_DOWN      = 3'd5
  } ramp_t;

  // Logarithmic brightness table, indexed by the linear level
  localparam logic [7:0] LOG_TABLE [256] = '{
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
    8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
    8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2,
    8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd3, 8'd3, 8'd3, 8'd3,
    8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd4, 8'd4, 8'd4, 8'd4, 8'd4, 8'd4,
    8'd4, 8'd4, 8'd5, 8'd5, 8'd5, 8'd5, 8'd5, 8'd5, 8'd5, 8'd6, 8'd6, 8'd6,
    8'd6, 8'd6, 8'd7, 8'd7, 8'd7, 8'd7, 8'd7, 8'd8, 8'd8, 8'd8, 8'd8, 8'd9,
    8'd9, 8'd9, 8'd9, 8'd10, 8'd10, 8'd10, 8'd10, 8'd11, 8'd11, 8'd11, 8'd12,
    8'd12, 8'd12, 8'd13, 8'd13, 8'd13, 8'd14, 8'd14, 8'd15, 8'd15, 8'd16,
    8'd16, 8'd16, 8'd17, 8'd17, 8'd18, 8'd18, 8'd19, 8'd19, 8'd20, 8'd21,
    8'd21, 8'd22, 8'd22, 8'd23, 8'd24, 8'd24, 8'd25, 8'd26, 8'd26, 8'd27,
    8'd28, 8'd29, 8'd30, 8'd30, 8'd31, 8'd32, 8'd33, 8'd34, 8'd35, 8'd36,
    8'd37, 8'd38, 8'd39, 8'd40, 8'd41, 8'd42, 8'd43, 8'd45, 8'd46, 8'd47,
    8'd48, 8'd50, 8'd51, 8'd53, 8'd54, 8'd56, 8'd57, 8'd59, 8'd60, 8'd62,
    8'd64, 8'd65, 8'd67, 8'd69, 8'd71, 8'd73, 8'd75, 8'd77, 8'd79, 8'd81,
    8'd84, 8'd86, 8'd88, 8'd91, 8'd93, 8'd96, 8'd98, 8'd101, 8'd104, 8'd107,
    8'd110, 8'd113, 8'd116, 8'd119, 8'd122, 8'd126, 8'd129, 8'd133, 8'd136,
    8'd140, 8'd144, 8'd148, 8'd152, 8'd156, 8'd161, 8'd165, 8'd170, 8'd174,
    8'd179, 8'd184, 8'd189, 8'd194, 8'd199, 8'd205, 8'd210, 8'd216, 8'd222,
    8'd228, 8'd235, 8'd241, 8'd248, 8'd255
  };

  // Truncating divide by 255 of a product of two bytes, by reciprocal
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    logic [16:0] q;
    t = {1'b0, x} + 17'd1;
    q = t + (t >> 8);
    return q[15:8];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/hsv_to_rgb_gamma_unit.sv -----
// Top level of the HSV to RGB converter with logarithmic brightness.
//
// Usage: present a colour on in_hue, in_saturation and in_brightness_level
// with in_valid high; the request is taken at a rising edge where in_stall
// is low. Each request yields one result on out_red, out_green and
// out_blue, taken at an edge where out_valid is high and out_stall low.
// Hue above 1535 is treated as 1535.
// Pipeline: five register stages (table lookup, v*s multiply, span divide,
// ramp multiply, level and routing), the first one capturing the request
// itself; out_valid rises once the request reaches the last stage.
// Throughput: one request per cycle while out_stall is low.
// Each stage holds its request while the stage after it is full and
// stalled; empty stages keep filling, so a stall loses and repeats nothing.
// in_stall rises only when every stage is full and out_stall is high.
// Reset (rst_n low, synchronous) empties all stages; payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module hsv_to_rgb_gamma_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [10:0] in_hue,
  input  wire logic [7:0]  in_saturation,
  input  wire logic [7:0]  in_brightness_level,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue
);

  // Stage valid bits
  logic s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r, s5_valid_r;
  logic s1_ready, s2_ready, s3_ready, s4_ready, s5_ready;

  // Stage 1 payload: value, saturation, ramp, mirrored position
  logic [7:0]         s1_v_r, s1_s_r, s1_pos_r;
  hsvg_pkg::ramp_t    s1_ramp_r;
  // Stage 2 payload: v*s product
  logic [15:0]        s2_prod_r;
  logic [7:0]         s2_v_r, s2_pos_r;
  hsvg_pkg::ramp_t    s2_ramp_r;
  // Stage 3 payload: span and min
  logic [7:0]         s3_span_r, s3_lo_r, s3_v_r, s3_pos_r;
  hsvg_pkg::ramp_t    s3_ramp_r;
  // Stage 4 payload: pos*span product
  logic [15:0]        s4_prod_r;
  logic [7:0]         s4_lo_r, s4_v_r;
  hsvg_pkg::ramp_t    s4_ramp_r;
  // Stage 5: output registers
  logic [7:0]         out_red_r, out_green_r, out_blue_r;

  // Stage 1 combinational inputs
  logic [10:0]        hue_sat;
  logic [7:0]         pos_nxt;
  hsvg_pkg::ramp_t    ramp_nxt;
  // Stage 3 and 5 combinational results
  logic [7:0]         span_nxt;
  logic [7:0]         level_nxt;
  logic [7:0]         red_nxt, green_nxt, blue_nxt;

  // Ready chain: a stage advances when empty or when the next one advances
  assign s5_ready = !s5_valid_r || !out_stall;
  assign s4_ready = !s4_valid_r || s5_ready;
  assign s3_ready = !s3_valid_r || s4_ready;
  assign s2_ready = !s2_valid_r || s3_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_stall = !s1_ready;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_r <= in_valid;
      if (s2_ready) s2_valid_r <= s1_valid_r;
      if (s3_ready) s3_valid_r <= s2_valid_r;
      if (s4_ready) s4_valid_r <= s3_valid_r;
      if (s5_ready) s5_valid_r <= s4_valid_r;
    end
  end

  // Saturate hue, split into ramp and position, mirror odd ramps
  always_comb begin
    hue_sat  = (in_hue > hsvg_pkg::HUE_MAX) ? hsvg_pkg::HUE_MAX : in_hue;
    ramp_nxt = hsvg_pkg::ramp_t'(hue_sat[10:8]);
    pos_nxt  = hue_sat[8] ? ~hue_sat[7:0] : hue_sat[7:0];
  end

  // Stage 1: brightness lookup
  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_v_r    <= hsvg_pkg::LOG_TABLE[in_brightness_level];
      s1_s_r    <= in_saturation;
      s1_ramp_r <= ramp_nxt;
      s1_pos_r  <= pos_nxt;
    end
  end

  // Stage 2: multiply value by saturation
  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_prod_r <= s1_v_r * s1_s_r;
      s2_v_r    <= s1_v_r;
      s2_ramp_r <= s1_ramp_r;
      s2_pos_r  <= s1_pos_r;
    end
  end

  // Stage 3: span = v*s/255, min = v - span
  assign span_nxt = hsvg_pkg::div255(s2_prod_r);

  always_ff @(posedge clk) begin
    if (s3_ready) begin
      s3_span_r <= span_nxt;
      s3_lo_r   <= s2_v_r - span_nxt;
      s3_v_r    <= s2_v_r;
      s3_ramp_r <= s2_ramp_r;
      s3_pos_r  <= s2_pos_r;
    end
  end

  // Stage 4: scale ramp position by span
  always_ff @(posedge clk) begin
    if (s4_ready) begin
      s4_prod_r <= s3_pos_r * s3_span_r;
      s4_lo_r   <= s3_lo_r;
      s4_v_r    <= s3_v_r;
      s4_ramp_r <= s3_ramp_r;
    end
  end

  // Stage 5: form level and route to channels by ramp
  always_comb begin
    level_nxt = hsvg_pkg::div255(s4_prod_r) + s4_lo_r;
    case (s4_ramp_r)
      hsvg_pkg::RAMP_RED_GREEN_UP: begin
        red_nxt = s4_v_r;    green_nxt = level_nxt; blue_nxt = s4_lo_r;
      end
      hsvg_pkg::RAMP_RED_DOWN: begin
        red_nxt = level_nxt; green_nxt = s4_v_r;    blue_nxt = s4_lo_r;
      end
      hsvg_pkg::RAMP_GREEN_BLUE_UP: begin
        red_nxt = s4_lo_r;   green_nxt = s4_v_r;    blue_nxt = level_nxt;
      end
      hsvg_pkg::RAMP_GREEN_DOWN: begin
        red_nxt = s4_lo_r;   green_nxt = level_nxt; blue_nxt = s4_v_r;
      end
      hsvg_pkg::RAMP_BLUE_RED_UP: begin
        red_nxt = level_nxt; green_nxt = s4_lo_r;   blue_nxt = s4_v_r;
      end
      default: begin
        red_nxt = s4_v_r;    green_nxt = s4_lo_r;   blue_nxt = level_nxt;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (s5_ready) begin
      out_red_r   <= red_nxt;
      out_green_r <= green_nxt;
      out_blue_r  <= blue_nxt;
    end
  end

  // Drive result channel
  assign out_valid = s5_valid_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;

endmodule

`default_nettype wire

// ----- rtl/core/hsvg_checker.sv -----
// Port-level checker for the HSV to RGB converter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module hsvg_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [7:0]  out_red,
  input wire logic [7:0]  out_green,
  input wire logic [7:0]  out_blue
);

  // Reset empties the pipeline
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // Input backs up only behind a stalled result
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a stalled result");

  // An accepted request reaches the output while out_stall stays low behind it
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall
    ##1 !out_stall |=> out_valid)
    else $error("request did not reach the output in time");

  // Hold a stalled result
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
    (out_valid && $stable(out_red) && $stable(out_green) && $stable(out_blue)))
    else $error("stalled result changed");

endmodule

bind hsv_to_rgb_gamma_unit hsvg_checker u_hsvg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_red   (out_red),
  .out_green (out_green),
  .out_blue  (out_blue)
);

`default_nettype wire

// ----- tb/sv/tb_hsv_to_rgb_gamma_unit.sv -----
// Self-checking testbench for the HSV to RGB converter with logarithmic brightness.
`timescale 1ns / 1ps

module tb_hsv_to_rgb_gamma_unit;

  localparam int N_DIR      = 24;
  localparam int N_ITEMS    = 1050;
  localparam int SEG_LEN    = 128;
  localparam int HOLD_AT    = N_DIR + 40;
  localparam int HOLD_LEN   = 40;
  localparam int DRAIN_CYC  = 12;
  localparam int MAX_SHOWN  = 10;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [10:0] hue;
    logic [7:0]  sat;
    logic [7:0]  lvl;
    logic        typed;
    rgb_t        rgb;
  } dir_row_t;

  // Directed requests; typed rows carry a color read straight off the ramps
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{11'd0,    8'd0,   8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
    '{11'd0,    8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd0}},
    '{11'd255,  8'd255, 8'd255, 1'b1, '{8'd255, 8'd255, 8'd0}},
    '{11'd256,  8'd255, 8'd255, 1'b1, '{8'd255, 8'd255, 8'd0}},
    '{11'd511,  8'd255, 8'd255, 1'b1, '{8'd0,   8'd255, 8'd0}},
    '{11'd512,  8'd255, 8'd255, 1'b1, '{8'd0,   8'd255, 8'd0}},
    '{11'd767,  8'd255, 8'd255, 1'b1, '{8'd0,   8'd255, 8'd255}},
    '{11'd768,  8'd255, 8'd255, 1'b1, '{8'd0,   8'd255, 8'd255}},
    '{11'd1023, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd0,   8'd255}},
    '{11'd1024, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd0,   8'd255}},
    '{11'd1279, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd255}},
    '{11'd1280, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd255}},
    '{11'd1535, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd0}},
    '{11'd1536, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd0}},
    '{11'd2047, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd0}},
    '{11'd700,  8'd0,   8'd255, 1'b1, '{8'd255, 8'd255, 8'd255}},
    '{11'd100,  8'd255, 8'd54,  1'b1, '{8'd0,   8'd0,   8'd0}},
    '{11'd300,  8'd0,   8'd55,  1'b1, '{8'd1,   8'd1,   8'd1}},
    '{11'd128,  8'd128, 8'd200, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{11'd900,  8'd1,   8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{11'd1400, 8'd254, 8'd254, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{11'd1700, 8'd77,  8'd180, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{11'd383,  8'd255, 8'd128, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{11'd1151, 8'd200, 8'd240, 1'b0, '{8'd0,   8'd0,   8'd0}}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [10:0] in_hue = '0;
  logic [7:0]  in_saturation = '0;
  logic [7:0]  in_brightness_level = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;

  rgb_t        pending_rgb_q [$];
  int          n_accepted = 0;
  int          n_checked = 0;
  int          n_errors = 0;
  int          n_mismatch = 0;
  int          n_back_pressure = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;

  hsv_to_rgb_gamma_unit uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_hue              (in_hue),
    .in_saturation       (in_saturation),
    .in_brightness_level (in_brightness_level),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_red             (out_red),
    .out_green           (out_green),
    .out_blue            (out_blue)
  );

  // Expected color for one request: brightness curve, span, ramp level, routing
  function automatic rgb_t hsv_color(input logic [10:0] hue, input logic [7:0] sat,
                                     input logic [7:0] lvl);
    logic [10:0]     h;
    int unsigned     v;
    int unsigned     span;
    int unsigned     lo;
    int unsigned     pos;
    int unsigned     level;
    hsvg_pkg::ramp_t ramp;
    rgb_t            c;
    h = (hue > hsvg_pkg::HUE_MAX) ? hsvg_pkg::HUE_MAX : hue;
    v = 32'(hsvg_pkg::LOG_TABLE[lvl]);
    span = (v * 32'(sat)) / 255;
    lo = v - span;
    ramp = hsvg_pkg::ramp_t'(h[10:8]);
    pos = 32'(h[7:0]);
    // Mirror the position on falling ramps
    if (h[8]) begin
      pos = 255 - pos;
    end
    level = (pos * span) / 255 + lo;
    case (ramp)
      hsvg_pkg::RAMP_RED_GREEN_UP: begin
        c.red = 8'(v);     c.green = 8'(level); c.blue = 8'(lo);
      end
      hsvg_pkg::RAMP_RED_DOWN: begin
        c.red = 8'(level); c.green = 8'(v);     c.blue = 8'(lo);
      end
      hsvg_pkg::RAMP_GREEN_BLUE_UP: begin
        c.red = 8'(lo);    c.green = 8'(v);     c.blue = 8'(level);
      end
      hsvg_pkg::RAMP_GREEN_DOWN: begin
        c.red = 8'(lo);    c.green = 8'(level); c.blue = 8'(v);
      end
      hsvg_pkg::RAMP_BLUE_RED_UP: begin
        c.red = 8'(level); c.green = 8'(lo);    c.blue = 8'(v);
      end
      default: begin
        c.red = 8'(v);     c.green = 8'(lo);    c.blue = 8'(level);
      end
    endcase
    return c;
  endfunction

  // Idle mix by request count: none, sender, receiver, both, repeating
  function automatic int phase_of(input int n);
    if (n < N_DIR) begin
      return 0;
    end
    return ((n - N_DIR) / SEG_LEN) % 4;
  endfunction

  function automatic int send_idle_pct(input int n);
    case (phase_of(n))
      1: return 53;
      3: return 20;
      default: return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct(input int n);
    case (phase_of(n))
      2: return 53;
      3: return 20;
      default: return 0;
    endcase
  endfunction

  initial begin
    forever #2 clk = ~clk;
  end

  // Hold reset low at the start, once
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Send requests: directed table first, then random colors
  always @(posedge clk) begin : send_proc
    int  idx;
    bit  offer;
    rgb_t exp_rgb;
    idx = n_accepted;
    offer = 1'b0;
    if (rst_n) begin
      if (in_valid && in_stall) begin
        n_back_pressure <= n_back_pressure + 1;
      end
      if (in_valid && !in_stall) begin
        if (idx < N_DIR && DIR_ROWS[idx].typed) begin
          exp_rgb = DIR_ROWS[idx].rgb;
        end else begin
          exp_rgb = hsv_color(in_hue, in_saturation, in_brightness_level);
        end
        pending_rgb_q.push_back(exp_rgb);
        idx = idx + 1;
        n_accepted <= idx;
      end
      // Offer the next request unless the current one is still held
      if (!in_valid || !in_stall) begin
        if (idx < N_ITEMS && $urandom_range(0, 99) >= send_idle_pct(idx)) begin
          offer = 1'b1;
          if (idx < N_DIR) begin
            in_hue <= DIR_ROWS[idx].hue;
            in_saturation <= DIR_ROWS[idx].sat;
            in_brightness_level <= DIR_ROWS[idx].lvl;
          end else begin
            in_hue <= ($urandom_range(0, 19) == 0) ? 11'($urandom_range(1536, 2047))
                                                   : 11'($urandom_range(0, 1535));
            case ($urandom_range(0, 9))
              0: in_saturation <= 8'd0;
              1: in_saturation <= 8'd255;
              default: in_saturation <= 8'($urandom_range(0, 255));
            endcase
            in_brightness_level <= ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 255))
                                                               : 8'($urandom_range(120, 255));
          end
        end
        in_valid <= offer;
      end
    end
  end

  // Drive output stall: random per phase, plus one long hold-off to fill the pipe
  always @(posedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (!hold_done && n_accepted >= HOLD_AT) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_LEN - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct(n_accepted));
      end
    end
  end

  // Compare each delivered color with the oldest pending one
  always @(posedge clk) begin : check_proc
    rgb_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_rgb_q.size() == 0) begin
        n_errors <= n_errors + 1;
        if (n_mismatch < MAX_SHOWN) begin
          $display("ERROR: unexpected result r=%0d g=%0d b=%0d", out_red, out_green, out_blue);
        end
        n_mismatch <= n_mismatch + 1;
      end else begin
        want = pending_rgb_q.pop_front();
        n_checked <= n_checked + 1;
        if (out_red !== want.red || out_green !== want.green || out_blue !== want.blue) begin
          n_errors <= n_errors + 1;
          if (n_mismatch < MAX_SHOWN) begin
            $display("ERROR: result %0d expected r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                     n_checked, want.red, want.green, want.blue,
                     out_red, out_green, out_blue);
          end
          n_mismatch <= n_mismatch + 1;
        end
      end
    end
  end

  // Wait for all requests and results, let the pipe settle, then report
  initial begin
    @(posedge clk);
    while (n_accepted < N_ITEMS || pending_rgb_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYC) @(posedge clk);
    $display("Sent %0d requests (%0d directed), checked %0d colors, %0d errors.",
             n_accepted, N_DIR, n_checked, n_errors + pending_rgb_q.size());
    $display("Covered idle/stall mixes and %0d input back-pressure cycles.", n_back_pressure);
    if (n_errors == 0 && pending_rgb_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Abort a hung run
  initial begin
    #400000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- hsv_to_rgb_gamma_unit.f -----
rtl/core/hsvg_pkg.sv
rtl/core/hsv_to_rgb_gamma_unit.sv
rtl/core/hsvg_checker.sv
tb/sv/tb_hsv_to_rgb_gamma_unit.sv
